### rtl/uehd_pkg.sv
`default_nettype none
package uehd_pkg;

   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned LenWidth    = 16;
   localparam int unsigned HdrBytes    = 4;
   localparam int unsigned HdrCntWidth = 2;
   localparam int unsigned ShiftWidth  = ByteWidth * (HdrBytes - 1);

   typedef struct packed {
      logic [ByteWidth-1:0] frame_byte;
      logic                 frame_last;
      logic                 frame_drop;
   } frame_type;

   typedef struct packed {
      logic      valid;
      frame_type frame;
   } result_type;

endpackage
`default_nettype wire

### rtl/uehd_if.sv
`default_nettype none
interface uehd_req_if ();
   logic                           valid;
   logic                           ready;
   logic [uehd_pkg::ByteWidth-1:0] rx_byte;
   logic                           transfer_end;

   modport source (output valid, output rx_byte, output transfer_end, input ready);
   modport sink (input valid, input rx_byte, input transfer_end, output ready);
endinterface

interface uehd_rsp_if ();
   logic                           valid;
   logic                           ready;
   logic [uehd_pkg::ByteWidth-1:0] frame_byte;
   logic                           frame_last;
   logic                           frame_drop;

   modport source (output valid, output frame_byte, output frame_last, output frame_drop,
                   input ready);
   modport sink (input valid, input frame_byte, input frame_last, input frame_drop,
                 output ready);
endinterface
`default_nettype wire

### rtl/uehd_parser.sv
`default_nettype none
module uehd_parser (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           in_valid,
   input  wire logic [uehd_pkg::ByteWidth-1:0] in_byte,
   input  wire logic                           in_end,
   output uehd_pkg::result_type                result
);

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_PAYLOAD = 2'd1,
      PH_DISCARD = 2'd2
   } phase_type;

   phase_type                             phase_ff, phase_in;
   logic [uehd_pkg::HdrCntWidth-1:0]      hdr_cnt_ff, hdr_cnt_in;
   logic [uehd_pkg::ShiftWidth-1:0]       hdr_shift_ff, hdr_shift_in;
   logic [uehd_pkg::LenWidth-1:0]         left_ff, left_in;

   logic [uehd_pkg::LenWidth-1:0]         left_dec;
   logic [uehd_pkg::LenWidth-1:0]         hdr_len;
   logic [uehd_pkg::LenWidth-1:0]         hdr_comp;

   assign left_dec = left_ff - uehd_pkg::LenWidth'(1);
   assign hdr_len  = hdr_shift_ff[uehd_pkg::LenWidth-1:0];
   assign hdr_comp = {in_byte, hdr_shift_ff[uehd_pkg::ShiftWidth-1:uehd_pkg::LenWidth]};

   always_comb begin
      phase_in     = phase_ff;
      hdr_cnt_in   = hdr_cnt_ff;
      hdr_shift_in = hdr_shift_ff;
      left_in      = left_ff;
      result       = '0;
      result.frame.frame_byte = in_byte;
      if (in_valid) begin
         unique case (phase_ff)
            PH_PAYLOAD: begin
               result.valid = 1'b1;
               left_in      = left_dec;
               if (left_dec == '0) begin
                  result.frame.frame_last = 1'b1;
                  phase_in = PH_HEADER;
               end else if (in_end) begin
                  // transfer ended mid-frame: close it and flag it for discard
                  result.frame.frame_last = 1'b1;
                  result.frame.frame_drop = 1'b1;
                  left_in  = '0;
                  phase_in = PH_HEADER;
               end
            end
            PH_DISCARD: begin
               if (in_end) begin
                  phase_in = PH_HEADER;
               end
            end
            default: begin
               phase_in = PH_HEADER;
               if (hdr_cnt_ff != uehd_pkg::HdrCntWidth'(uehd_pkg::HdrBytes - 1)) begin
                  hdr_shift_in = hdr_shift_ff
                               | (uehd_pkg::ShiftWidth'(in_byte) << {hdr_cnt_ff, 3'b000});
                  hdr_cnt_in   = hdr_cnt_ff + uehd_pkg::HdrCntWidth'(1);
                  if (in_end) begin
                     hdr_cnt_in   = '0;
                     hdr_shift_in = '0;
                  end
               end else begin
                  hdr_cnt_in   = '0;
                  hdr_shift_in = '0;
                  if (hdr_len != ~hdr_comp) begin
                     if (!in_end) begin
                        phase_in = PH_DISCARD;
                     end
                  end else if (hdr_len != '0 && !in_end) begin
                     phase_in = PH_PAYLOAD;
                     left_in  = hdr_len;
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         hdr_cnt_ff   <= '0;
         hdr_shift_ff <= '0;
         left_ff      <= '0;
      end else begin
         phase_ff     <= phase_in;
         hdr_cnt_ff   <= hdr_cnt_in;
         hdr_shift_ff <= hdr_shift_in;
         left_ff      <= left_in;
      end
   end

   a_drop_needs_last: assert property (@(posedge clock) disable iff (reset)
      result.valid && result.frame.frame_drop |-> result.frame.frame_last)
      else $error("drop flag without last flag");

   a_payload_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> left_ff != '0)
      else $error("payload phase with no bytes left");

   a_hdr_idle: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_HEADER |-> hdr_cnt_ff == '0 && hdr_shift_ff == '0)
      else $error("header collector not cleared outside header phase");

endmodule
`default_nettype wire

### rtl/uehd_outbuf.sv
`default_nettype none
module uehd_outbuf (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire uehd_pkg::result_type push,
   output logic                      in_ready,
   uehd_rsp_if.source                rsp
);

   logic                main_valid_ff, main_valid_in;
   logic                skid_valid_ff, skid_valid_in;
   uehd_pkg::frame_type main_ff, main_in;
   uehd_pkg::frame_type skid_ff, skid_in;
   logic                pop;

   assign pop      = main_valid_ff && rsp.ready;
   assign in_ready = !skid_valid_ff;

   assign rsp.valid      = main_valid_ff;
   assign rsp.frame_byte = main_ff.frame_byte;
   assign rsp.frame_last = main_ff.frame_last;
   assign rsp.frame_drop = main_ff.frame_drop;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      priority if (skid_valid_ff) begin
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push.valid && (!main_valid_ff || pop)) begin
         main_in       = push.frame;
         main_valid_in = 1'b1;
      end else if (push.valid) begin
         // main still waiting on the sink: park the new item
         skid_in       = push.frame;
         skid_valid_in = 1'b1;
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry held while main entry empty");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(push.valid && skid_valid_ff))
      else $error("item pushed into full buffer");

   a_skid_moves_up: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && pop |=> main_valid_ff && main_ff == $past(skid_ff))
      else $error("skid entry not promoted on pop");

endmodule
`default_nettype wire

### rtl/usb_ether_length_header_deframer.sv
`default_nettype none
// Length-header deframer for USB Ethernet bulk-in transfers. Takes one transfer byte per
// cycle on req_ch while ready is high (transfer_end marks a transfer's last byte); each
// frame opens with a 4-byte little-endian header, a 16-bit length then its one's
// complement, and its payload bytes come out registered on rsp_ch with frame_last on the
// final byte. A frame cut off by transfer end closes with frame_last and frame_drop both
// set; header mismatches discard the rest of the transfer; zero-length frames and
// incomplete headers give nothing. Sustained rate is one byte per cycle while rsp_ch is
// ready; a two-entry output buffer keeps req_ch.ready high unless two results wait.
module usb_ether_length_header_deframer (
   input  wire logic  clock,
   input  wire logic  reset,
   uehd_req_if.sink   req_ch,
   uehd_rsp_if.source rsp_ch
);

   uehd_pkg::result_type result;
   logic                 buf_ready;
   logic                 accept;

   assign req_ch.ready = buf_ready;
   assign accept       = req_ch.valid && buf_ready;

   uehd_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .in_byte  (req_ch.rx_byte),
      .in_end   (req_ch.transfer_end),
      .result   (result)
   );

   uehd_outbuf u_outbuf (
      .clock    (clock),
      .reset    (reset),
      .push     (result),
      .in_ready (buf_ready),
      .rsp      (rsp_ch)
   );

endmodule
`default_nettype wire
